// File: sv/button_dimmer_sleep_timer_core_defines.svh
// Assertion macros shared by the checker of button_dimmer_sleep_timer_core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BUTTON_DIMMER_SLEEP_TIMER_CORE_DEFINES_SVH
`define BUTTON_DIMMER_SLEEP_TIMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDST_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bdst_pkg.sv
// Package for the button dimmer sleep timer: mode codes, register map,
// reset values and the structs passed between modules. No dependencies.
package bdst_pkg;

    // Lamp modes. Codes 6 and 7 never arise and are handled as OFF.
    typedef enum logic [2:0] {
        MODE_OFF = 3'd0,
        MODE_ON  = 3'd1,
        MODE_T1  = 3'd2,
        MODE_T2  = 3'd3,
        MODE_T3  = 3'd4,
        MODE_T4  = 3'd5
    } mode_t;

    // Configuration register map (word index = paddr[3:2]).
    localparam int REG_ADDR_W = 4;
    localparam logic [1:0] REG_SHORT_MIN  = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_SLEEP_STEP = 2'd2;

    localparam logic [15:0] SHORT_MIN_RESET  = 16'd50;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [21:0] SLEEP_STEP_RESET = 22'd1800000;
    localparam logic [23:0] SLEEP_X3_RESET   = 24'd5400000;

    localparam logic [15:0] PRESS_MAX = 16'hFFFF;
    localparam logic [23:0] OFFT_MAX  = 24'hFFFFFF;
    localparam logic [7:0]  DUTY_FULL = 8'd255;

    typedef struct packed {
        logic [15:0] short_min;
        logic [15:0] long_press;
        logic [21:0] sleep_step;
        logic [23:0] sleep_x3;    // three sleep steps, kept ready for timer T3
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [4:0]  lamps;
        logic [7:0]  duty;
    } result_t;

    function automatic mode_t next_mode(input mode_t m);
        mode_t n;
        unique case (m)
            MODE_OFF: n = MODE_ON;
            MODE_ON:  n = MODE_T1;
            MODE_T1:  n = MODE_T2;
            MODE_T2:  n = MODE_T3;
            MODE_T3:  n = MODE_T4;
            default:  n = MODE_OFF;
        endcase
        return n;
    endfunction

    function automatic logic is_timer(input mode_t m);
        return (m == MODE_T1) || (m == MODE_T2) || (m == MODE_T3) || (m == MODE_T4);
    endfunction

endpackage

// File: sv/bdst_cfg_regs.sv
// APB-style configuration registers of the button dimmer sleep timer.
// Depends on bdst_pkg for the register map, reset values and cfg_t.
module bdst_cfg_regs
    import bdst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [15:0] short_min_reg;
    logic [15:0] long_press_reg;
    logic [21:0] sleep_step_reg;
    logic [23:0] sleep_x3_reg;
    logic [1:0]  reg_index;
    logic        wr_en;
    logic [23:0] step_ext;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign step_ext  = {2'b00, pwdata[21:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_min_reg  <= SHORT_MIN_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            sleep_step_reg <= SLEEP_STEP_RESET;
            sleep_x3_reg   <= SLEEP_X3_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_SHORT_MIN:  short_min_reg  <= pwdata[15:0];
                REG_LONG_PRESS: long_press_reg <= pwdata[15:0];
                REG_SLEEP_STEP:
                begin
                    sleep_step_reg <= pwdata[21:0];
                    sleep_x3_reg   <= step_ext + {step_ext[22:0], 1'b0};
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_SHORT_MIN:  prdata = {16'd0, short_min_reg};
            REG_LONG_PRESS: prdata = {16'd0, long_press_reg};
            REG_SLEEP_STEP: prdata = {10'd0, sleep_step_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.short_min  = short_min_reg;
    assign cfg.long_press = long_press_reg;
    assign cfg.sleep_step = sleep_step_reg;
    assign cfg.sleep_x3   = sleep_x3_reg;

endmodule

// File: sv/bdst_update.sv
// Per-tick state update of the button dimmer sleep timer: mode, press
// counter, dimming phase, off-timer, duty and lamps. Depends on bdst_pkg.
module bdst_update
    import bdst_pkg::*;
#(
    parameter int DIM_INTERVAL = 50
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  logic    held,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int PHASE_W = (DIM_INTERVAL > 1) ? $clog2(DIM_INTERVAL) : 1;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(DIM_INTERVAL - 1);

    mode_t              mode_reg;
    mode_t              mode_next;
    mode_t              mode_step;
    logic [15:0]        press_reg;
    logic [15:0]        press_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [23:0]        off_reg;
    logic [23:0]        off_next;
    logic [23:0]        off_inc;
    logic [7:0]         duty_reg;
    logic [7:0]         duty_next;
    logic [7:0]         duty_dim;
    logic [4:0]         lamps_reg;
    logic [4:0]         lamps_next;
    logic               press_done;
    logic               expired;

    // Counters and dimming, before the mode is settled.
    always_comb
    begin
        off_inc    = off_reg;
        press_next = '0;
        phase_next = '0;
        duty_dim   = duty_reg;
        press_done = 1'b0;
        if (is_timer(mode_reg) && (off_reg != OFFT_MAX))
        begin
            off_inc = off_reg + 24'd1;
        end
        if (held)
        begin
            press_next = (press_reg != PRESS_MAX) ? press_reg + 16'd1 : press_reg;
            phase_next = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;
            if ((press_next >= cfg.long_press) && (phase_next == '0) &&
                (mode_reg != MODE_OFF))
            begin
                duty_dim = duty_reg - 8'd1;
            end
        end
        else
        begin
            press_done = (press_reg != 16'd0) && (press_reg >= cfg.short_min) &&
                         (press_reg <= cfg.long_press);
        end
    end

    // Next mode: a finished short press steps the cycle, then the off-timer
    // may send a timer mode back to OFF.
    always_comb
    begin
        mode_step = press_done ? next_mode(mode_reg) : mode_reg;
        unique case (mode_step)
            MODE_T1: expired = off_inc > {2'b00, cfg.sleep_step};
            MODE_T2: expired = off_inc > {1'b0, cfg.sleep_step, 1'b0};
            MODE_T3: expired = off_inc > cfg.sleep_x3;
            MODE_T4: expired = off_inc > {cfg.sleep_step, 2'b00};
            default: expired = 1'b0;
        endcase
        unique case (mode_step)
            MODE_ON, MODE_T1, MODE_T2, MODE_T3, MODE_T4:
                mode_next = expired ? MODE_OFF : mode_step;
            default:
                mode_next = MODE_OFF;
        endcase
    end

    // Action of the settled mode.
    always_comb
    begin
        unique case (mode_next)
            MODE_ON:
            begin
                lamps_next = lamps_reg | 5'b00001;
                duty_next  = (duty_dim == 8'd0) ? DUTY_FULL : duty_dim;
                off_next   = '0;
            end
            MODE_T1:
            begin
                lamps_next = lamps_reg | 5'b00010;
                duty_next  = duty_dim;
                off_next   = off_inc;
            end
            MODE_T2:
            begin
                lamps_next = lamps_reg | 5'b00100;
                duty_next  = duty_dim;
                off_next   = off_inc;
            end
            MODE_T3:
            begin
                lamps_next = lamps_reg | 5'b01000;
                duty_next  = duty_dim;
                off_next   = off_inc;
            end
            MODE_T4:
            begin
                lamps_next = lamps_reg | 5'b10000;
                duty_next  = duty_dim;
                off_next   = off_inc;
            end
            default:
            begin
                lamps_next = '0;
                duty_next  = '0;
                off_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_OFF;
            press_reg <= '0;
            phase_reg <= '0;
            off_reg   <= '0;
            duty_reg  <= '0;
            lamps_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            press_reg <= press_next;
            phase_reg <= phase_next;
            off_reg   <= off_next;
            duty_reg  <= duty_next;
            lamps_reg <= lamps_next;
        end
    end

    assign result.mode  = mode_next;
    assign result.lamps = lamps_next;
    assign result.duty  = duty_next;

endmodule

// File: sv/button_dimmer_sleep_timer_core.sv
// Top level of the button dimmer sleep timer core.
// Depends on bdst_pkg, bdst_cfg_regs and bdst_update.

// One input transaction carries the button level for one tick and yields
// exactly one result transaction with the mode, the indicator lamps and the
// PWM duty after that tick. The core sustains one transaction per clock
// cycle while the output does not stall: an accepted tick is held in the
// input register, the whole update is worked out combinationally from it,
// and the result is loaded into the output register, where it is offered.
// The result register holds a stalled result while the input register
// still takes the next tick; stalls on the output reach the input only
// once both registers are full. The three configuration registers sit
// at byte addresses 0x0 (short_min_ticks), 0x4 (long_press_ticks) and 0x8
// (sleep_step_ticks); they are to be written only while no tick is in flight.
// DIM_INTERVAL (1 to 63) sets how many held ticks lie between two duty steps
// during a long press.
module button_dimmer_sleep_timer_core
    import bdst_pkg::*;
#(
    parameter int DIM_INTERVAL = 50
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  button_held,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            mode_now,
    output logic [4:0]            indicator_bits,
    output logic [7:0]            pwm_duty
);

    cfg_t    cfg;
    result_t result;
    result_t result_reg;
    logic    in_valid_reg;
    logic    held_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    fire;
    logic    in_accept;

    bdst_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The result register can take a new value when it is empty or its
    // current transaction leaves in this cycle.
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    bdst_update #(
        .DIM_INTERVAL (DIM_INTERVAL)
    ) u_update (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .held   (held_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Input register: filled on accept, emptied when its tick is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            held_reg <= button_held;
        end
    end

    // Output register: loaded with each processed tick, cleared once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mode_now       = result_reg.mode;
    assign indicator_bits = result_reg.lamps;
    assign pwm_duty       = result_reg.duty;

endmodule

// File: sv/bdst_checker.sv
// Port-level checker for button_dimmer_sleep_timer_core, bound to the top level.
// Depends on bdst_pkg and button_dimmer_sleep_timer_core_defines.svh.
`include "button_dimmer_sleep_timer_core_defines.svh"

module bdst_checker
    import bdst_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] mode_now,
    input logic [4:0] indicator_bits,
    input logic [7:0] pwm_duty
);

    // A stalled result transaction stays offered and unchanged.
    `BDST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(mode_now) && $stable(indicator_bits) && $stable(pwm_duty), "stalled result changed")

    // With the result register empty, the input side never stalls.
    `BDST_ASSERT_SAME(a_no_false_stall, !out_valid, !in_stall, "input stalled with empty output")

    // OFF shows a dark lamp and no indicators.
    `BDST_ASSERT_SAME(a_off_dark, out_valid && mode_now == MODE_OFF, indicator_bits == 5'd0 && pwm_duty == 8'd0, "OFF with lamps or duty")

    // ON always lights its indicator and never shows a zero duty.
    `BDST_ASSERT_SAME(a_on_lit, out_valid && mode_now == MODE_ON, indicator_bits[0] && pwm_duty != 8'd0, "ON without indicator or with zero duty")

endmodule

bind button_dimmer_sleep_timer_core bdst_checker u_bdst_checker (.*);
